@@ src/erpm_pkg.sv @@
// shared types and constants for the encoder rpm pid motor drive
package erpm_pkg;

    localparam int unsigned MS_PER_MINUTE = 60000;

    typedef enum logic [2:0] {
        CFG_KP  = 3'd0,
        CFG_KI  = 3'd1,
        CFG_KD  = 3'd2,
        CFG_CPR = 3'd3,
        CFG_MAX = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_DIVQ   = 4'd2,
        OP_MULDQ  = 4'd3,
        OP_DIVSPD = 4'd4,
        OP_ERR    = 4'd5,
        OP_MULP   = 4'd6,
        OP_MULI   = 4'd7,
        OP_MULD   = 4'd8,
        OP_SUMPID = 4'd9,
        OP_MULPRV = 4'd10,
        OP_MULRCP = 4'd11,
        OP_CLAMP  = 4'd12,
        OP_MULPWM = 4'd13,
        OP_DIVPWM = 4'd14,
        OP_FINISH = 4'd15
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_start;
        logic mul_start;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic mul_busy;
    } t_status;

endpackage

@@ src/erpm_datapath.sv @@
// datapath: shared multiplier and divider, pid state and result registers
module erpm_datapath #(
    parameter int SPEED_FRAC_BITS = 8,
    parameter int PWM_FULL_SCALE  = 255
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  erpm_pkg::t_cmd         i_cmd,
    output erpm_pkg::t_status      o_status,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [15:0]            i_cfg_data,
    input  logic signed [31:0]     i_encoder_count,
    input  logic [15:0]            i_elapsed_ms,
    input  logic signed [18:0]     i_target_speed,
    input  logic                   i_stop_now,
    output logic [7:0]             o_pwm_magnitude,
    output logic                   o_direction_forward,
    output logic signed [18:0]     o_measured_speed
);
    localparam int PW  = $clog2(PWM_FULL_SCALE + 1) + 1;
    localparam int DW  = 64;
    localparam int CW  = $clog2(DW + 1);
    localparam int MXW = 10 + SPEED_FRAC_BITS + 1;
    // reciprocal of the full-scale pwm, exact for |last_pwm * full| below 2^PRV_N
    localparam int PRV_N = $clog2(PWM_FULL_SCALE + 1) + 10 + SPEED_FRAC_BITS;
    localparam int PRV_K = PRV_N + $clog2(PWM_FULL_SCALE);
    localparam logic [63:0] PRV_RECIP =
        ((64'd1 << PRV_K) + 64'(PWM_FULL_SCALE - 1)) / 64'(PWM_FULL_SCALE);

    logic signed [15:0] r_kp, r_ki, r_kd;
    logic [15:0]        r_cpr;
    logic [9:0]         r_max;
    logic [31:0]        r_last_count;
    logic signed [19:0] r_last_error;
    logic signed [31:0] r_error_sum;
    logic signed [PW-1:0] r_last_pwm;

    logic [31:0]        r_cnt;
    logic [15:0]        r_ms;
    logic signed [18:0] r_target;
    logic               r_stop;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_tmp;
    logic signed [19:0] r_err;
    logic signed [18:0] r_speed;
    logic signed [MXW-1:0] r_full;

    // shared multiplier: 32x32 signed, operands and busy flag registered at start, then product registered from them
    logic signed [31:0] r_ma, r_mb;
    logic signed [63:0] r_mp;
    logic               r_mbusy;

    // shared restoring divider, one quotient bit per cycle, magnitudes
    logic [DW-1:0]      r_dq, r_drem;
    logic [DW-1:0]      r_dd;
    logic [CW-1:0]      r_dcnt;
    logic               r_dneg;
    logic               r_dbusy;
    logic signed [63:0] w_dnum;
    logic [DW-1:0]      w_dden;

    logic [DW:0]        w_trial;
    logic [DW-1:0]      w_rsh;
    logic [DW-1:0]      w_num_mag;
    logic signed [63:0] w_quot;
    logic signed [63:0] w_sum;
    logic signed [63:0] w_e32;
    logic signed [63:0] w_mfull;
    logic signed [63:0] w_pid;
    logic signed [63:0] w_prv;

    assign o_status.div_busy = r_dbusy;
    assign o_status.mul_busy = r_mbusy;

    assign w_rsh     = {r_drem[DW-2:0], r_dq[DW-1]};
    assign w_trial   = {1'b0, w_rsh} - {1'b0, r_dd};
    assign w_num_mag = w_dnum[63] ? DW'(-w_dnum) : DW'(w_dnum);
    assign w_quot    = r_dneg ? -$signed(r_dq) : $signed(r_dq);
    assign w_mfull   = 64'(r_full);
    assign w_sum     = 64'(r_error_sum) + 64'(r_err);
    assign w_e32     = (w_sum > 64'sd2147483647) ? 64'sd2147483647 :
                       (w_sum < -64'sd2147483648) ? -64'sd2147483648 : w_sum;
    // q8.8 gain scaling, truncated toward zero
    assign w_pid     = (r_acc + (r_acc[63] ? 64'sd255 : 64'sd0)) >>> 8;
    assign w_prv     = r_mp >>> PRV_K;

    // divider operand selection
    always_comb begin
        w_dnum = r_mp;
        w_dden = DW'(1);
        unique case (i_cmd.op)
            erpm_pkg::OP_DIVQ: begin
                w_dnum = 64'(erpm_pkg::MS_PER_MINUTE);
                w_dden = (r_ms == 16'd0) ? DW'(1) : DW'(r_ms);
            end
            erpm_pkg::OP_DIVSPD: begin
                w_dnum = r_mp <<< SPEED_FRAC_BITS;
                w_dden = (r_cpr == 16'd0) ? DW'(1) : DW'(r_cpr);
            end
            erpm_pkg::OP_DIVPWM: begin
                w_dnum = r_mp;
                w_dden = DW'(r_full);
            end
            default: begin
                w_dnum = r_mp;
                w_dden = DW'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0; r_ki <= '0; r_kd <= '0;
            r_cpr <= 16'd1; r_max <= 10'd330;
            r_last_count <= '0; r_last_error <= '0;
            r_error_sum <= '0; r_last_pwm <= '0;
            r_dbusy <= 1'b0; r_mbusy <= 1'b0; r_dcnt <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    erpm_pkg::CFG_KP:  r_kp  <= $signed(i_cfg_data);
                    erpm_pkg::CFG_KI:  r_ki  <= $signed(i_cfg_data);
                    erpm_pkg::CFG_KD:  r_kd  <= $signed(i_cfg_data);
                    erpm_pkg::CFG_CPR: r_cpr <= i_cfg_data;
                    erpm_pkg::CFG_MAX: r_max <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            r_mbusy <= i_cmd.mul_start;
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= CW'(DW);
                r_dq    <= w_num_mag;
                r_drem  <= '0;
                r_dd    <= w_dden;
                r_dneg  <= w_dnum[63];
            end else if (r_dbusy) begin
                r_dq <= {r_dq[DW-2:0], ~w_trial[DW]};
                r_drem <= w_trial[DW] ? w_rsh : w_trial[DW-1:0];
                r_dcnt <= r_dcnt - CW'(1);
                if (r_dcnt == CW'(1)) r_dbusy <= 1'b0;
            end
            unique case (i_cmd.op)
                erpm_pkg::OP_LOAD: begin
                    r_cnt <= i_encoder_count; r_ms <= i_elapsed_ms;
                    r_target <= i_target_speed; r_stop <= i_stop_now;
                    r_full <= MXW'({(r_max == 10'd0) ? 10'd1 : r_max} << SPEED_FRAC_BITS);
                end
                erpm_pkg::OP_MULDQ: begin
                    r_ma <= $signed(r_cnt - r_last_count);
                    r_mb <= w_quot[31:0];
                    r_last_count <= r_cnt;
                end
                erpm_pkg::OP_DIVSPD: r_acc <= r_mp;
                erpm_pkg::OP_ERR: begin
                    r_speed <= (w_quot > 64'sd262143) ? 19'sh3FFFF :
                               (w_quot < -64'sd262144) ? -19'sd262144 : w_quot[18:0];
                    r_err   <= 20'(r_target) - 20'((w_quot > 64'sd262143) ? 64'sd262143 :
                               (w_quot < -64'sd262144) ? -64'sd262144 : w_quot);
                end
                erpm_pkg::OP_MULP: begin
                    r_ma <= 32'(r_kp); r_mb <= 32'(r_err);
                    r_error_sum <= w_e32[31:0];
                    r_acc <= '0;
                end
                erpm_pkg::OP_MULI: begin
                    r_ma <= 32'(r_ki); r_mb <= r_error_sum;
                    r_acc <= r_acc + r_mp;
                end
                erpm_pkg::OP_MULD: begin
                    r_ma <= 32'(r_kd); r_mb <= 32'(r_err) - 32'(r_last_error);
                    r_acc <= r_acc + r_mp;
                    r_last_error <= r_err;
                end
                erpm_pkg::OP_SUMPID: r_acc <= r_acc + r_mp;
                erpm_pkg::OP_MULPRV: begin
                    r_tmp <= w_pid;
                    r_ma <= 32'(r_last_pwm); r_mb <= 32'(r_full);
                end
                erpm_pkg::OP_MULRCP: begin
                    r_ma <= r_mp[63] ? 32'(-r_mp) : r_mp[31:0];
                    r_mb <= 32'(PRV_RECIP);
                end
                erpm_pkg::OP_CLAMP: begin
                    r_acc <= (r_last_pwm[PW-1] ? -w_prv : w_prv) + r_tmp;
                end
                erpm_pkg::OP_MULPWM: begin
                    r_ma <= (r_acc > w_mfull) ? 32'(w_mfull) :
                            (r_acc < -w_mfull) ? -32'(w_mfull) : r_acc[31:0];
                    r_mb <= 32'(PWM_FULL_SCALE);
                end
                erpm_pkg::OP_FINISH: begin
                    r_last_pwm <= r_stop ? '0 : w_quot[PW-1:0];
                    o_pwm_magnitude <= r_stop ? 8'd0 :
                        8'(w_quot[63] ? -w_quot : w_quot);
                    o_direction_forward <= r_stop ? 1'b1 : !w_quot[63];
                    o_measured_speed <= r_speed;
                end
                default: ;
            endcase
            if (r_mbusy) r_mp <= r_ma * r_mb;
        end
    end

    ap_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_dbusy) else $error("divider did not start");
    ap_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dbusy && r_dcnt == CW'(1) && !i_cmd.div_start) |=> !r_dbusy)
        else $error("divider overran");
    ap_err_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == erpm_pkg::OP_MULP) |=> $stable(r_err))
        else $error("error changed during pid");
endmodule

@@ src/erpm_ctrl.sv @@
// controller: sequences the datapath through one control tick
module erpm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  erpm_pkg::t_status i_status,
    output erpm_pkg::t_cmd    o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state    r_state, n_state;
    erpm_pkg::t_op r_op, n_op;
    logic      r_ovalid, n_ovalid;
    logic      w_fire;

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign w_fire  = (r_state == S_RUN) && !i_status.div_busy && !i_status.mul_busy;

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_ovalid = r_ovalid;
        o_cmd.op = erpm_pkg::OP_NONE;
        o_cmd.div_start = 1'b0;
        o_cmd.mul_start = 1'b0;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_valid && !r_ovalid) begin
                o_cmd.op = erpm_pkg::OP_LOAD;
                n_op = erpm_pkg::OP_DIVQ;
                n_state = S_RUN;
            end
            S_RUN: if (w_fire) begin
                o_cmd.op = r_op;
                o_cmd.div_start = (r_op == erpm_pkg::OP_DIVQ) ||
                    (r_op == erpm_pkg::OP_DIVSPD) || (r_op == erpm_pkg::OP_DIVPWM);
                o_cmd.mul_start = (r_op == erpm_pkg::OP_MULDQ) ||
                    (r_op == erpm_pkg::OP_MULP) || (r_op == erpm_pkg::OP_MULI) ||
                    (r_op == erpm_pkg::OP_MULD) || (r_op == erpm_pkg::OP_MULPRV) ||
                    (r_op == erpm_pkg::OP_MULRCP) || (r_op == erpm_pkg::OP_MULPWM);
                if (r_op == erpm_pkg::OP_FINISH) n_state = S_WAIT;
                else n_op = erpm_pkg::t_op'(r_op + 4'd1);
            end
            S_WAIT: if (!r_ovalid || i_ready) begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op <= erpm_pkg::OP_NONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
            r_ovalid <= n_ovalid;
        end
    end

    ap_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    ap_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    ap_start_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.div_start && o_cmd.mul_start)) else $error("two units started");
endmodule

@@ src/encoder_rpm_pid_motor_drive.sv @@
// top level: encoder rpm pid motor drive
// channel  dir  handshake              payload
// in       in   i_valid / o_ready      encoder_count elapsed_ms target_speed stop_now
// out      out  o_valid / i_ready      pwm_magnitude direction_forward measured_speed
// cfg      in   i_cfg_we               i_cfg_index i_cfg_data
// a result is offered after three passes of the 64-step divider, seven
// multiplies and the remaining single-step operations
// reset is synchronous active low and restores configuration, pid state and the controller
// the result holds in its register until taken; a new beat is not taken
// while a result still waits or while a tick is still in progress
module encoder_rpm_pid_motor_drive #(
    parameter int SPEED_FRAC_BITS = 8,
    parameter int PWM_FULL_SCALE  = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_encoder_count,
    input  logic [15:0]        i_elapsed_ms,
    input  logic signed [18:0] i_target_speed,
    input  logic               i_stop_now,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_pwm_magnitude,
    output logic               o_direction_forward,
    output logic signed [18:0] o_measured_speed,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    erpm_pkg::t_cmd    w_cmd;
    erpm_pkg::t_status w_status;

    erpm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    erpm_datapath #(
        .SPEED_FRAC_BITS(SPEED_FRAC_BITS), .PWM_FULL_SCALE(PWM_FULL_SCALE)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_status(w_status),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_encoder_count(i_encoder_count), .i_elapsed_ms(i_elapsed_ms),
        .i_target_speed(i_target_speed), .i_stop_now(i_stop_now),
        .o_pwm_magnitude(o_pwm_magnitude), .o_direction_forward(o_direction_forward),
        .o_measured_speed(o_measured_speed)
    );
endmodule
